### sv/vnch_pkg.sv
// Shared constants, types and arithmetic helpers of the value noise column height unit.
package vnch_pkg;

   // Chunk geometry and vertical scaling
   localparam int CHUNK_LEVELS = 256;
   localparam int HEIGHT_SCALE = 1;

   // Field and datapath widths
   localparam int COORD_W    = 4;
   localparam int HEIGHT_W   = 8;
   localparam int BLOCK_W    = 16;
   localparam int BASE_W     = 8;
   localparam int AMP_W      = 8;
   localparam int FREQ_W     = 24;
   localparam int SEED_W     = 32;
   localparam int SCALED_W   = 13;   // holds 255*16 and the chunk level count
   localparam int POS_W      = COORD_W + FREQ_W;
   localparam int FRAC_W     = 16;
   localparam int CELL_W     = POS_W - FRAC_W;
   localparam int SMOOTH_W   = FRAC_W + 1;
   localparam int NOISE_W    = 24;
   localparam int HASH_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int HEIGHT_MAX = (CHUNK_LEVELS - 1 < 255) ? CHUNK_LEVELS - 1 : 255;

   // Hash constants
   localparam logic [HASH_W-1:0] PRIME_X  = 32'd73856093;
   localparam logic [HASH_W-1:0] PRIME_Z  = 32'd19349663;
   localparam logic [HASH_W-1:0] WANG_XOR = 32'd61;
   localparam logic [HASH_W-1:0] WANG_MUL = 32'h27d4eb2d;

   // Register reset values
   localparam logic [BASE_W-1:0]  BASE_HEIGHT_RST = 8'd32;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 8'd16;
   localparam logic [FREQ_W-1:0]  FREQUENCY_RST   = 24'd3277;
   localparam logic [SEED_W-1:0]  NOISE_SEED_RST  = 32'd1337;
   localparam logic [BLOCK_W-1:0] TOP_BLOCK_RST   = 16'd1;
   localparam logic [BLOCK_W-1:0] FILL_BLOCK_RST  = 16'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_HEIGHT = 3'd0,
      CSR_AMPLITUDE   = 3'd1,
      CSR_FREQUENCY   = 3'd2,
      CSR_NOISE_SEED  = 3'd3,
      CSR_TOP_BLOCK   = 3'd4,
      CSR_FILL_BLOCK  = 3'd5
   } csr_index_type;

   // Load enables of the three hash mixing stages
   typedef struct packed {
      logic mix_a;
      logic mix_b;
      logic mix_c;
   } hash_en_type;

   // Linear interpolation between a and b by weight s (Q1.16, 0..65536), rounded
   function automatic logic [NOISE_W-1:0] blend(input logic [NOISE_W-1:0] a,
                                                input logic [NOISE_W-1:0] b,
                                                input logic [SMOOTH_W-1:0] s);
      logic [SMOOTH_W-1:0]            w;
      logic [NOISE_W+SMOOTH_W-1:0]    pa;
      logic [NOISE_W+SMOOTH_W-1:0]    pb;
      logic [NOISE_W+SMOOTH_W+1:0]    sum;
      w   = 17'd65536 - s;
      pa  = (NOISE_W+SMOOTH_W)'(a) * (NOISE_W+SMOOTH_W)'(w);
      pb  = (NOISE_W+SMOOTH_W)'(b) * (NOISE_W+SMOOTH_W)'(s);
      sum = (NOISE_W+SMOOTH_W+2)'(pa) + (NOISE_W+SMOOTH_W+2)'(pb)
            + (NOISE_W+SMOOTH_W+2)'(32768);
      return sum[FRAC_W+NOISE_W-1:FRAC_W];
   endfunction

endpackage

### sv/vnch_req_if.sv
// Request channel: one column coordinate per transaction.
interface vnch_req_if import vnch_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] column_x;
   logic [COORD_W-1:0] column_z;

   modport source (output valid, output column_x, output column_z, input ready);
   modport sink   (input valid, input column_x, input column_z, output ready);
endinterface

### sv/vnch_rsp_if.sv
// Response channel: column height and block ids per transaction.
interface vnch_rsp_if import vnch_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  out_x;
   logic [COORD_W-1:0]  out_z;
   logic [HEIGHT_W-1:0] surface_height;
   logic [BLOCK_W-1:0]  top_block;
   logic [BLOCK_W-1:0]  fill_block;

   modport source (output valid, output out_x, output out_z, output surface_height,
                   output top_block, output fill_block, input ready);
   modport sink   (input valid, input out_x, input out_z, input surface_height,
                   input top_block, input fill_block, output ready);
endinterface

### sv/vnch_corner_hash.sv
// Three-stage Wang hash of one corner key, keeping the low 24 bits.
module vnch_corner_hash import vnch_pkg::*; (
   input  logic                clock,
   input  hash_en_type         en,
   input  logic [HASH_W-1:0]   key,
   output logic [NOISE_W-1:0]  value
);

   logic [HASH_W-1:0]  mix_a_ff, mix_a_in;
   logic [HASH_W-1:0]  mix_b_ff, mix_b_in;
   logic [NOISE_W-1:0] mix_c_ff, mix_c_in;
   logic [HASH_W-1:0]  fold_a;
   logic [HASH_W-1:0]  fold_b;
   logic [HASH_W-1:0]  fold_c;

   always_comb begin
      fold_a   = (key ^ WANG_XOR) ^ (key >> 16);
      mix_a_in = fold_a + {fold_a[HASH_W-4:0], 3'b000};   // times 9
      fold_b   = mix_a_ff ^ (mix_a_ff >> 4);
      mix_b_in = fold_b * WANG_MUL;
      fold_c   = mix_b_ff ^ (mix_b_ff >> 15);
      mix_c_in = fold_c[NOISE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.mix_a) begin
         mix_a_ff <= mix_a_in;
      end
      if (en.mix_b) begin
         mix_b_ff <= mix_b_in;
      end
      if (en.mix_c) begin
         mix_c_ff <= mix_c_in;
      end
   end

   assign value = mix_c_ff;

endmodule

### sv/value_noise_column_height_unit.sv
// Value noise column height unit: 8-stage pipeline, one column per transaction.
// Throughput: one transaction per cycle; a stage stalls only when it and all
// stages after it hold data that the response side has not taken.
// The response is offered once the transaction reaches the last stage register.
// Reset (synchronous): empties the pipeline and loads the register defaults.
module value_noise_column_height_unit import vnch_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   vnch_req_if.sink              req_ch,
   vnch_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NSTAGE = 8;

   // Configuration registers
   logic [BASE_W-1:0]  base_height_ff;
   logic [AMP_W-1:0]   amplitude_ff;
   logic [FREQ_W-1:0]  frequency_ff;
   logic [SEED_W-1:0]  noise_seed_ff;
   logic [BLOCK_W-1:0] top_block_ff;
   logic [BLOCK_W-1:0] fill_block_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff <= BASE_HEIGHT_RST;
         amplitude_ff   <= AMPLITUDE_RST;
         frequency_ff   <= FREQUENCY_RST;
         noise_seed_ff  <= NOISE_SEED_RST;
         top_block_ff   <= TOP_BLOCK_RST;
         fill_block_ff  <= FILL_BLOCK_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_HEIGHT: base_height_ff <= csr_wdata[BASE_W-1:0];
            CSR_AMPLITUDE:   amplitude_ff   <= csr_wdata[AMP_W-1:0];
            CSR_FREQUENCY:   frequency_ff   <= csr_wdata[FREQ_W-1:0];
            CSR_NOISE_SEED:  noise_seed_ff  <= csr_wdata[SEED_W-1:0];
            CSR_TOP_BLOCK:   top_block_ff   <= csr_wdata[BLOCK_W-1:0];
            CSR_FILL_BLOCK:  fill_block_ff  <= csr_wdata[BLOCK_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: a stage loads when it is empty or the next one loads
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE:0]   stage_rdy;

   always_comb begin
      stage_rdy[NSTAGE] = rsp_ch.ready;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
   end

   assign req_ch.ready = stage_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_rdy[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (stage_rdy[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Coordinate echo travels with the transaction
   logic [COORD_W-1:0] x_pipe_ff [NSTAGE];
   logic [COORD_W-1:0] z_pipe_ff [NSTAGE];

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         x_pipe_ff[0] <= req_ch.column_x;
         z_pipe_ff[0] <= req_ch.column_z;
      end
      for (int i = 1; i < NSTAGE; i++) begin
         if (stage_rdy[i]) begin
            x_pipe_ff[i] <= x_pipe_ff[i-1];
            z_pipe_ff[i] <= z_pipe_ff[i-1];
         end
      end
   end

   // Stage 0: scale coordinates by frequency
   logic [POS_W-1:0] sx_ff, sx_in;
   logic [POS_W-1:0] sz_ff, sz_in;

   assign sx_in = POS_W'(req_ch.column_x) * POS_W'(frequency_ff);
   assign sz_in = POS_W'(req_ch.column_z) * POS_W'(frequency_ff);

   // Stage 1: spatial hash keys of the four corners, fraction squared and 3-2t
   logic [CELL_W-1:0]   cx0, cx1, cz0, cz1;
   logic [HASH_W-1:0]   hx0, hx1, hz0, hz1;
   logic [HASH_W-1:0]   key00_ff, key10_ff, key01_ff, key11_ff;
   logic [HASH_W-1:0]   key00_in, key10_in, key01_in, key11_in;
   logic [2*FRAC_W-1:0] ttx_ff, ttx_in, ttz_ff, ttz_in;
   logic [FRAC_W+1:0]   px_ff, px_in, pz_ff, pz_in;
   logic [FRAC_W-1:0]   tx, tz;

   always_comb begin
      cx0      = sx_ff[POS_W-1:FRAC_W];
      cz0      = sz_ff[POS_W-1:FRAC_W];
      cx1      = cx0 + CELL_W'(1);   // cell index stays below 3841
      cz1      = cz0 + CELL_W'(1);
      hx0      = HASH_W'(cx0) * PRIME_X;
      hx1      = HASH_W'(cx1) * PRIME_X;
      hz0      = HASH_W'(cz0) * PRIME_Z;
      hz1      = HASH_W'(cz1) * PRIME_Z;
      key00_in = hx0 ^ hz0 ^ noise_seed_ff;
      key10_in = hx1 ^ hz0 ^ noise_seed_ff;
      key01_in = hx0 ^ hz1 ^ noise_seed_ff;
      key11_in = hx1 ^ hz1 ^ noise_seed_ff;
      tx       = sx_ff[FRAC_W-1:0];
      tz       = sz_ff[FRAC_W-1:0];
      ttx_in   = (2*FRAC_W)'(tx) * (2*FRAC_W)'(tx);
      ttz_in   = (2*FRAC_W)'(tz) * (2*FRAC_W)'(tz);
      px_in    = (FRAC_W+2)'(3 * 65536) - {1'b0, tx, 1'b0};
      pz_in    = (FRAC_W+2)'(3 * 65536) - {1'b0, tz, 1'b0};
   end

   // Stages 2..4: corner hashes in four parallel units
   hash_en_type        hash_en;
   logic [NOISE_W-1:0] v00, v10, v01, v11;

   assign hash_en.mix_a = stage_rdy[2];
   assign hash_en.mix_b = stage_rdy[3];
   assign hash_en.mix_c = stage_rdy[4];

   vnch_corner_hash u_hash00 (.clock(clock), .en(hash_en), .key(key00_ff), .value(v00));
   vnch_corner_hash u_hash10 (.clock(clock), .en(hash_en), .key(key10_ff), .value(v10));
   vnch_corner_hash u_hash01 (.clock(clock), .en(hash_en), .key(key01_ff), .value(v01));
   vnch_corner_hash u_hash11 (.clock(clock), .en(hash_en), .key(key11_ff), .value(v11));

   // Smoothstep alongside: t*t*(3-2t) in stage 2, rounding in stage 3
   localparam int EASE_W = 2 * FRAC_W + FRAC_W + 2;

   logic [EASE_W-1:0]   ex_ff, ex_in, ez_ff, ez_in;
   logic [EASE_W:0]     ex_rnd, ez_rnd;
   logic [SMOOTH_W-1:0] smx3_ff, smx3_in, smz3_ff, smz3_in;
   logic [SMOOTH_W-1:0] smx4_ff, smz4_ff;

   always_comb begin
      ex_in   = EASE_W'(ttx_ff) * EASE_W'(px_ff);
      ez_in   = EASE_W'(ttz_ff) * EASE_W'(pz_ff);
      ex_rnd  = (EASE_W+1)'(ex_ff) + (EASE_W+1)'(64'h8000_0000);
      ez_rnd  = (EASE_W+1)'(ez_ff) + (EASE_W+1)'(64'h8000_0000);
      smx3_in = ex_rnd[2*FRAC_W+SMOOTH_W-1:2*FRAC_W];
      smz3_in = ez_rnd[2*FRAC_W+SMOOTH_W-1:2*FRAC_W];
   end

   // Stage 5: blend along x; stage 6: blend along z
   logic [NOISE_W-1:0]  r0_ff, r1_ff, n_ff;
   logic [SMOOTH_W-1:0] smz5_ff;

   // Stage 7: height from noise, amplitude and base
   logic [SCALED_W-1:0]         base_sc, base_cl, amp_sc, noise_amp;
   logic [NOISE_W+SCALED_W-1:0] noise_prod;
   logic [NOISE_W+SCALED_W:0]   noise_rnd;
   logic [SCALED_W:0]           height_sum;
   logic [HEIGHT_W-1:0]         height_ff, height_in;

   always_comb begin
      base_sc    = SCALED_W'(base_height_ff) * SCALED_W'(HEIGHT_SCALE);
      amp_sc     = SCALED_W'(amplitude_ff) * SCALED_W'(HEIGHT_SCALE);
      base_cl    = (base_sc > SCALED_W'(CHUNK_LEVELS)) ? SCALED_W'(CHUNK_LEVELS) : base_sc;
      noise_prod = (NOISE_W+SCALED_W)'(n_ff) * (NOISE_W+SCALED_W)'(amp_sc);
      noise_rnd  = (NOISE_W+SCALED_W+1)'(noise_prod) + (NOISE_W+SCALED_W+1)'(24'h80_0000);
      noise_amp  = noise_rnd[NOISE_W+SCALED_W-1:NOISE_W];
      height_sum = (SCALED_W+1)'(base_cl) + (SCALED_W+1)'(noise_amp);
      height_in  = (height_sum > (SCALED_W+1)'(HEIGHT_MAX)) ? HEIGHT_W'(HEIGHT_MAX)
                                                           : height_sum[HEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         sx_ff <= sx_in;
         sz_ff <= sz_in;
      end
      if (stage_rdy[1]) begin
         key00_ff <= key00_in;
         key10_ff <= key10_in;
         key01_ff <= key01_in;
         key11_ff <= key11_in;
         ttx_ff   <= ttx_in;
         ttz_ff   <= ttz_in;
         px_ff    <= px_in;
         pz_ff    <= pz_in;
      end
      if (stage_rdy[2]) begin
         ex_ff <= ex_in;
         ez_ff <= ez_in;
      end
      if (stage_rdy[3]) begin
         smx3_ff <= smx3_in;
         smz3_ff <= smz3_in;
      end
      if (stage_rdy[4]) begin
         smx4_ff <= smx3_ff;
         smz4_ff <= smz3_ff;
      end
      if (stage_rdy[5]) begin
         r0_ff   <= blend(v00, v10, smx4_ff);
         r1_ff   <= blend(v01, v11, smx4_ff);
         smz5_ff <= smz4_ff;
      end
      if (stage_rdy[6]) begin
         n_ff <= blend(r0_ff, r1_ff, smz5_ff);
      end
      if (stage_rdy[7]) begin
         height_ff <= height_in;
      end
   end

   assign rsp_ch.valid          = valid_ff[NSTAGE-1];
   assign rsp_ch.out_x          = x_pipe_ff[NSTAGE-1];
   assign rsp_ch.out_z          = z_pipe_ff[NSTAGE-1];
   assign rsp_ch.surface_height = height_ff;
   assign rsp_ch.top_block      = top_block_ff;
   assign rsp_ch.fill_block     = fill_block_ff;

   // A draining response side never blocks a new request
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("request stalled while response side drains");

   // An accepted transaction lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> valid_ff[0])
      else $error("accepted transaction lost at pipeline entry");

   // The last interior stage hands over to the output register without loss
   a_output_handoff: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NSTAGE-2] && stage_rdy[NSTAGE-1] |=> rsp_ch.valid)
      else $error("transaction lost before output register");

endmodule
